[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define OSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define OSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/osm_pkg.sv]
// Shared types and codes for the order-statistic multiset.
// No dependencies.
package osm_pkg;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_RANK   = 3'd2;
    localparam logic [2:0] ACT_KTH    = 3'd3;
    localparam logic [2:0] ACT_PRED   = 3'd4;
    localparam logic [2:0] ACT_SUCC   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic [15:0] TOTAL_LIMIT    = 16'hFFFF;

    // Partial result rippled along the cell chain, one cell per cycle.
    typedef struct packed {
        logic [15:0]        below;
        logic [15:0]        run;
        logic               kfound;
        logic signed [31:0] kkey;
        logic               predf;
        logic signed [31:0] pkey;
        logic               succf;
        logic signed [31:0] skey;
        logic               hit;
        logic               hit_full;
        logic               hit_one;
    } t_wave;

    // Broadcast to every cell: operand and update strobes.
    typedef struct packed {
        logic signed [31:0] x;
        logic [15:0]        pos;
        logic               ins_new;
        logic               inc;
        logic               dec;
        logic               del;
    } t_bcast;

endpackage

[rtl/osm_if.sv]
// Request and response channel interfaces of the multiset.
// Depends on nothing.
interface osm_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [15:0]        position;
    modport source (output valid, action, value, position, input ready);
    modport sink   (input valid, action, value, position, output ready);
endinterface

interface osm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] answer;
    logic [1:0]         status;
    logic [15:0]        held_total;
    modport source (output valid, answer, status, held_total, input ready);
    modport sink   (input valid, answer, status, held_total, output ready);
endinterface

[rtl/osm_cell.sv]
// One sorted slot of the multiset: key, multiplicity, wave stage.
// Uses osm_pkg.
module osm_cell
    import osm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_valid,
    input  logic                  i_left_lt,
    input  logic signed [31:0]    i_left_key,
    input  logic [COUNT_BITS-1:0] i_left_mult,
    input  logic signed [31:0]    i_right_key,
    input  logic [COUNT_BITS-1:0] i_right_mult,
    input  t_bcast                i_bc,
    input  t_wave                 i_wave,
    output t_wave                 o_wave,
    output logic                  o_lt,
    output logic signed [31:0]    o_key,
    output logic [COUNT_BITS-1:0] o_mult
);
    localparam logic [COUNT_BITS-1:0] MULT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] MULT_ONE = COUNT_BITS'(1);

    logic signed [31:0]    r_key;
    logic [COUNT_BITS-1:0] r_mult;
    t_wave                 r_wave;
    t_wave                 n_wave;
    logic                  w_lt, w_eq, w_gt;
    logic [15:0]           w_m16;

    assign w_lt  = i_valid && (r_key < i_bc.x);
    assign w_eq  = i_valid && (r_key == i_bc.x);
    assign w_gt  = i_valid && !w_lt && !w_eq;
    assign w_m16 = 16'(r_mult);

    always_comb begin
        n_wave = i_wave;
        if (w_lt) begin
            n_wave.below = i_wave.below + w_m16;
            n_wave.predf = 1'b1;
            n_wave.pkey  = r_key;
        end
        if (i_valid) begin
            n_wave.run = i_wave.run + w_m16;
        end
        if (i_valid && !i_wave.kfound && (n_wave.run >= i_bc.pos)) begin
            n_wave.kfound = 1'b1;
            n_wave.kkey   = r_key;
        end
        if (w_gt && !i_wave.succf) begin
            n_wave.succf = 1'b1;
            n_wave.skey  = r_key;
        end
        if (w_eq) begin
            n_wave.hit      = 1'b1;
            n_wave.hit_full = (r_mult == MULT_MAX);
            n_wave.hit_one  = (r_mult == MULT_ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_wave <= n_wave;
        if (i_bc.ins_new && !w_lt) begin
            if (i_left_lt) begin
                r_key  <= i_bc.x;
                r_mult <= MULT_ONE;
            end else begin
                r_key  <= i_left_key;
                r_mult <= i_left_mult;
            end
        end else if (i_bc.del && !w_lt) begin
            r_key  <= i_right_key;
            r_mult <= i_right_mult;
        end else if (i_bc.inc && w_eq) begin
            r_mult <= r_mult + MULT_ONE;
        end else if (i_bc.dec && w_eq) begin
            r_mult <= r_mult - MULT_ONE;
        end
    end

    assign o_wave = r_wave;
    assign o_lt   = w_lt;
    assign o_key  = r_key;
    assign o_mult = r_mult;
endmodule

[rtl/order_statistic_multiset.sv]
// Order-statistic multiset of signed 32-bit keys.
// Channels: i_req (action, value, position) in, o_rsp (answer, status,
// held_total) out, valid/ready handshake, an item moves when both are high.
// Each item gives exactly one response item.
// The keys sit in a chain of CAPACITY sorted cells. All cells compare the
// item's value at once; the rank, kth, predecessor and successor results
// then ripple cell to cell through a registered stage in each cell, and
// after the ripple an update step follows in which the cells shift for
// an insert or remove and the response is loaded into its register.
// One item is worked on at a time; the next is accepted once the
// response is loaded. The response sits in an output register; while
// the receiver stalls, a new item can be accepted and run its ripple,
// and its update waits until the old response is taken.
// Reset (synchronous, active low) empties the multiset at once: no
// clearing pass, held_total reads zero.
// Uses osm_pkg, osm_if, osm_cell.
`include "assert_macros.svh"
module order_statistic_multiset
    import osm_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    osm_req_if.sink  i_req,
    osm_rsp_if.source o_rsp
);
    localparam int UW = $clog2(CAPACITY + 1);
    localparam int CW = $clog2(CAPACITY);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WAVE   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]         r_state;
    logic [CW-1:0]      r_cnt;
    logic [UW-1:0]      r_used;
    logic [15:0]        r_total;
    logic [2:0]         r_act;
    logic signed [31:0] r_x;
    logic [15:0]        r_pos;
    logic               r_ovalid;
    logic signed [31:0] r_ans;
    logic [1:0]         r_stat;

    logic               w_fire;
    t_bcast             w_bc;
    t_wave              w_zero;
    t_wave              w_last;
    logic               w_ins_ok, w_ins_new, w_inc, w_dec, w_del;
    logic [15:0]        n_total;
    logic signed [31:0] n_ans;
    logic [1:0]         n_stat;

    t_wave                 w_wave [CAPACITY];
    logic                  w_lt   [CAPACITY];
    logic signed [31:0]    w_key  [CAPACITY];
    logic [COUNT_BITS-1:0] w_mult [CAPACITY];

    assign w_zero = '0;
    assign w_last = w_wave[CAPACITY-1];

    assign w_fire    = (r_state == S_COMMIT) && (!r_ovalid || o_rsp.ready);
    assign w_ins_ok  = (r_act == ACT_INSERT) && (r_total < TOTAL_LIMIT);
    assign w_inc     = w_fire && w_ins_ok && w_last.hit && !w_last.hit_full;
    assign w_ins_new = w_fire && w_ins_ok && !w_last.hit && (r_used < UW'(CAPACITY));
    assign w_dec     = w_fire && (r_act == ACT_REMOVE) && w_last.hit && !w_last.hit_one;
    assign w_del     = w_fire && (r_act == ACT_REMOVE) && w_last.hit && w_last.hit_one;

    assign w_bc = '{x: r_x, pos: r_pos, ins_new: w_ins_new, inc: w_inc,
                    dec: w_dec, del: w_del};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        osm_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
            .i_clk       (i_clk),
            .i_valid     (UW'(i) < r_used),
            .i_left_lt   ((i == 0) ? 1'b1 : w_lt[(i == 0) ? 0 : i-1]),
            .i_left_key  (w_key[(i == 0) ? 0 : i-1]),
            .i_left_mult (w_mult[(i == 0) ? 0 : i-1]),
            .i_right_key (w_key[(i == CAPACITY-1) ? i : i+1]),
            .i_right_mult(w_mult[(i == CAPACITY-1) ? i : i+1]),
            .i_bc        (w_bc),
            .i_wave      ((i == 0) ? w_zero : w_wave[(i == 0) ? 0 : i-1]),
            .o_wave      (w_wave[i]),
            .o_lt        (w_lt[i]),
            .o_key       (w_key[i]),
            .o_mult      (w_mult[i])
        );
    end

    always_comb begin
        n_total = r_total;
        if (w_inc || w_ins_new) begin
            n_total = r_total + 16'd1;
        end else if (w_dec || w_del) begin
            n_total = r_total - 16'd1;
        end
        n_ans  = '0;
        n_stat = ST_OK;
        case (r_act)
            ACT_INSERT: begin
                if (!(w_inc || w_ins_new)) begin
                    n_stat = ST_FULL;
                end
            end
            ACT_REMOVE: n_ans = '0;
            // 32-bit sum: a full count below gives 65536
            ACT_RANK:   n_ans = $signed(32'(w_last.below) + 32'd1);
            ACT_KTH: begin
                if ((r_pos == 16'd0) || (r_pos > r_total)) begin
                    n_stat = ST_RANGE;
                end else begin
                    n_ans = w_last.kkey;
                end
            end
            ACT_PRED:   n_ans = w_last.predf ? w_last.pkey : INT_MIN;
            ACT_SUCC:   n_ans = w_last.succf ? w_last.skey : INT_MAX;
            default:    n_ans = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_used   <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= S_WAVE;
                        r_cnt   <= '0;
                    end
                end
                S_WAVE: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(CAPACITY - 1)) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (w_fire) begin
                        r_state  <= S_IDLE;
                        r_total  <= n_total;
                        if (w_ins_new) begin
                            r_used <= r_used + UW'(1);
                        end else if (w_del) begin
                            r_used <= r_used - UW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_act <= i_req.action;
            r_x   <= i_req.value;
            r_pos <= i_req.position;
        end
        if (w_fire) begin
            r_ans  <= n_ans;
            r_stat <= n_stat;
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.answer     = r_ans;
    assign o_rsp.status     = r_stat;
    assign o_rsp.held_total = r_total;

    `OSM_ASSERT_IMP(a_used_cap, i_clk, i_rst_n, 1'b1, r_used <= UW'(CAPACITY))
    `OSM_ASSERT_IMP(a_total_ge_used, i_clk, i_rst_n, 1'b1, 32'(r_total) >= 32'(r_used))
    `OSM_ASSERT_NEXT(a_fire_out, i_clk, i_rst_n, w_fire, r_ovalid && r_state == S_IDLE)
endmodule
